FILE: rtl/blhc_pkg.sv
package blhc_pkg;
    localparam int CMD_W   = 2;
    localparam int CFG_W   = 11;
    localparam int LIM_W   = 4;
    localparam int COUNT_W = 14;
    localparam int STAMP_W = 32;
    localparam int PROBE_W = 4;
    localparam int IDX_W   = 1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [IDX_W-1:0] CFG_BUCKET_COUNT = 1'b0;
    localparam logic [IDX_W-1:0] CFG_BUCKET_LIMIT = 1'b1;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 11'd13;
    localparam logic [LIM_W-1:0] BUCKET_LIMIT_RST = 4'd3;
endpackage

FILE: rtl/blhc_front.sv
module blhc_front #(
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32,
    parameter int BW         = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [blhc_pkg::CMD_W-1:0]   i_command,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic [VALUE_BITS-1:0]        i_value,
    input  logic [blhc_pkg::CFG_W-1:0]   i_nb,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output logic [blhc_pkg::CMD_W-1:0]   o_cmd,
    output logic [KEY_BITS-1:0]          o_key,
    output logic [VALUE_BITS-1:0]        o_val,
    output logic [BW-1:0]                o_bkt,
    output logic                         o_busy
);
    import blhc_pkg::*;

    localparam int STEPS = (KEY_BITS + 3) / 4;
    localparam int KPAD  = STEPS * 4;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate             r_state, n_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [KPAD-1:0]     r_sh;
    logic [CFG_W-1:0]    r_rem, n_rem;
    logic [CW-1:0]       r_cnt;

    always_comb begin
        logic [CFG_W:0] t;
        t     = '0;
        n_rem = r_rem;
        for (int k = 0; k < 4; k++) begin
            t = {n_rem, r_sh[KPAD-1-k]};
            if (t >= {1'b0, i_nb}) begin
                t = t - {1'b0, i_nb};
            end
            n_rem = t[CFG_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_accept) n_state = F_DIV;
            F_DIV:  if (r_cnt == CW'(STEPS - 1)) n_state = F_PUSH;
            F_PUSH: if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_accept) begin
            r_cmd <= i_command;
            r_key <= i_key;
            r_val <= i_value;
            r_sh  <= KPAD'(i_key);
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == F_DIV) begin
            r_sh  <= r_sh << 4;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    assign o_cmd    = r_cmd;
    assign o_key    = r_key;
    assign o_val    = r_val;
    assign o_bkt    = BW'(r_rem);
    assign o_busy   = (r_state != F_IDLE);
endmodule

FILE: rtl/blhc_queue.sv
module blhc_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    logic [W-1:0] r_slot [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_data;
    end

    assign o_data  = r_slot[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
endmodule

FILE: rtl/blhc_back.sv
module blhc_back #(
    parameter int MAX_BUCKETS = 1024,
    parameter int WAYS        = 8,
    parameter int KEY_BITS    = 64,
    parameter int VALUE_BITS  = 32,
    parameter int BW          = 10,
    parameter int FW          = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    output logic                         o_q_pop,
    input  logic [blhc_pkg::CMD_W-1:0]   i_cmd,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic [VALUE_BITS-1:0]        i_val,
    input  logic [BW-1:0]                i_bkt,
    input  logic [blhc_pkg::CFG_W-1:0]   i_nb,
    input  logic [FW-1:0]                i_lim,
    output logic                         o_clearing,
    output logic                         o_valid,
    output logic                         o_found,
    output logic [VALUE_BITS-1:0]        o_read_value,
    output logic [blhc_pkg::PROBE_W-1:0] o_probes,
    output logic                         o_evicted,
    output logic [KEY_BITS-1:0]          o_evicted_key
);
    import blhc_pkg::*;

    localparam int DEPTH = MAX_BUCKETS * WAYS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] val;
        logic [STAMP_W-1:0]    stamp;
    } t_entry;

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_FILL = 9'b000000100,
        S_SCAN = 9'b000001000,
        S_DEC  = 9'b000010000,
        S_SHRD = 9'b000100000,
        S_SHWR = 9'b001000000,
        S_APP  = 9'b010000000,
        S_FIN  = 9'b100000000
    } t_bstate;

    t_entry         mem [DEPTH];
    logic [FW-1:0]  fill_mem [MAX_BUCKETS];

    t_bstate             r_state;
    logic [BW-1:0]       r_clr;
    logic [CMD_W-1:0]    r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [BW-1:0]       r_bkt;
    logic [STAMP_W-1:0]  r_clock;
    logic [COUNT_W-1:0]  r_count;
    logic [FW-1:0]       r_fq, r_n, r_rd, r_dvi, r_m, r_lru, r_sh;
    logic                r_dv, r_hit;
    logic [VALUE_BITS-1:0] r_mval;
    logic [STAMP_W-1:0]  r_lstamp;
    logic [KEY_BITS-1:0] r_lkey;
    t_entry              r_mq;

    logic                r_found, r_ev;
    logic [VALUE_BITS-1:0] r_rv;
    logic [PROBE_W-1:0]  r_probes;
    logic [KEY_BITS-1:0] r_evk;

    logic [AW-1:0]  base;
    logic           rd_en, we, fwe;
    logic [AW-1:0]  rd_addr, waddr;
    t_entry         wdata;
    logic [BW-1:0]  faddr;
    logic [FW-1:0]  fdata;
    logic           heavy;
    logic [COUNT_W+2:0] load5;

    assign base  = AW'(r_bkt) * AW'(WAYS);
    assign load5 = {r_count, 2'b00} + (COUNT_W+3)'(r_count);
    assign heavy = load5 > (COUNT_W+3)'({i_nb, 2'b00});

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = base + AW'(r_rd);
        we      = 1'b0;
        waddr   = base + AW'(r_sh);
        wdata   = r_mq;
        fwe     = 1'b0;
        faddr   = r_bkt;
        fdata   = '0;
        unique case (r_state)
            S_CLR: begin
                fwe   = 1'b1;
                faddr = r_clr;
            end
            S_SCAN: begin
                rd_en = (r_rd < r_n);
            end
            S_DEC: begin
                if (r_hit && (r_cmd == CMD_INSERT || r_cmd == CMD_SEARCH)) begin
                    we    = 1'b1;
                    waddr = base + AW'(r_m);
                    wdata = {r_key, (r_cmd == CMD_INSERT) ? r_val : r_mval, r_clock};
                end
            end
            S_SHRD: begin
                if (FW'(r_sh + 1'b1) < r_n) begin
                    rd_en   = 1'b1;
                    rd_addr = base + AW'(r_sh) + AW'(1);
                end else if (r_cmd != CMD_INSERT) begin
                    fwe   = 1'b1;
                    fdata = r_n - 1'b1;
                end
            end
            S_SHWR: begin
                we = 1'b1;
            end
            S_APP: begin
                if (r_n < FW'(WAYS)) begin
                    we    = 1'b1;
                    waddr = base + AW'(r_n);
                    wdata = {r_key, r_val, r_clock};
                    fwe   = 1'b1;
                    fdata = r_n + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (rd_en) r_mq <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (fwe) fill_mem[faddr] <= fdata;
        if (r_state == S_IDLE) r_fq <= fill_mem[i_bkt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_clock <= '0;
            r_count <= '0;
            r_dv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == BW'(MAX_BUCKETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd    <= i_cmd;
                        r_key    <= i_key;
                        r_val    <= i_val;
                        r_bkt    <= i_bkt;
                        r_found  <= 1'b0;
                        r_rv     <= '0;
                        r_probes <= '0;
                        r_ev     <= 1'b0;
                        r_evk    <= '0;
                        if (i_cmd == CMD_INSERT || i_cmd == CMD_SEARCH) begin
                            r_clock <= r_clock + 1'b1;
                        end
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_n     <= r_fq;
                    r_rd    <= '0;
                    r_dv    <= 1'b0;
                    r_hit   <= 1'b0;
                    r_lru   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_dv  <= rd_en;
                    r_dvi <= r_rd;
                    if (rd_en) r_rd <= r_rd + 1'b1;
                    if (r_dv) begin
                        if (!r_hit && r_mq.key == r_key) begin
                            r_hit  <= 1'b1;
                            r_m    <= r_dvi;
                            r_mval <= r_mq.val;
                        end
                        if (r_dvi == '0 || r_mq.stamp < r_lstamp) begin
                            r_lru    <= r_dvi;
                            r_lstamp <= r_mq.stamp;
                            r_lkey   <= r_mq.key;
                        end
                    end
                    if (!rd_en && !r_dv) r_state <= S_DEC;
                end
                S_DEC: begin
                    r_state <= S_FIN;
                    case (r_cmd)
                        CMD_INSERT: begin
                            if (r_hit) begin
                                r_found <= 1'b1;
                            end else if (r_n != '0 && (r_n >= i_lim || heavy)) begin
                                r_ev    <= 1'b1;
                                r_evk   <= r_lkey;
                                r_sh    <= r_lru;
                                r_state <= S_SHRD;
                            end else begin
                                r_state <= S_APP;
                            end
                        end
                        CMD_SEARCH: begin
                            r_found  <= r_hit;
                            r_rv     <= r_hit ? r_mval : '0;
                            r_probes <= r_hit ? PROBE_W'(r_m + 1'b1) : PROBE_W'(r_n);
                        end
                        CMD_REMOVE: begin
                            if (r_hit) begin
                                r_found <= 1'b1;
                                r_sh    <= r_m;
                                r_state <= S_SHRD;
                            end
                        end
                        default: ;
                    endcase
                end
                S_SHRD: begin
                    if (rd_en) begin
                        r_state <= S_SHWR;
                    end else begin
                        r_n     <= r_n - 1'b1;
                        r_count <= r_count - 1'b1;
                        r_state <= (r_cmd == CMD_INSERT) ? S_APP : S_FIN;
                    end
                end
                S_SHWR: begin
                    r_sh    <= r_sh + 1'b1;
                    r_state <= S_SHRD;
                end
                S_APP: begin
                    if (r_n < FW'(WAYS)) r_count <= r_count + 1'b1;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_q_pop       = (r_state == S_IDLE) && !i_q_empty;
    assign o_clearing    = (r_state == S_CLR);
    assign o_valid       = (r_state == S_FIN);
    assign o_found       = r_found;
    assign o_read_value  = r_rv;
    assign o_probes      = r_probes;
    assign o_evicted     = r_ev;
    assign o_evicted_key = r_evk;
endmodule

FILE: rtl/bucket_lru_hash_cache_unit.sv
// Bucketed key/value cache with per-bucket least-recently-used eviction.
// Command channel: drive start with command, key and value; the word is
// taken at a clock edge where start is high and busy is low.
// Result channel: o_valid pulses for one cycle with found, read value,
// probes, evicted flag and evicted key. The receiver cannot stall; every
// command yields exactly one result word.
// Config port: i_cfg_we with i_cfg_idx (0 bucket count, 1 bucket limit)
// and i_cfg_data; write only while idle.
// Front: key mod bucket count, four key bits per cycle, and busy stays
// high until the word is pushed into the queue. A two-word queue feeds
// the back engine, which reads the bucket fill, scans n stored entries on
// one memory read port, then reads and rewrites each entry moved on
// eviction or removal. The front can take a new command while the back
// engine still works on earlier ones.
// Reset: the back engine clears the bucket fill table, one bucket per
// cycle, holding busy high until done.
module bucket_lru_hash_cache_unit #(
    parameter int MAX_BUCKETS = 1024,
    parameter int WAYS        = 8,
    parameter int KEY_BITS    = 64,
    parameter int VALUE_BITS  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [blhc_pkg::CMD_W-1:0]    i_command,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic signed [VALUE_BITS-1:0]  i_value,
    input  logic                          i_cfg_we,
    input  logic [blhc_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [blhc_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    output logic                          o_found,
    output logic signed [VALUE_BITS-1:0]  o_read_value,
    output logic [blhc_pkg::PROBE_W-1:0]  o_probes,
    output logic                          o_evicted,
    output logic [KEY_BITS-1:0]           o_evicted_key
);
    import blhc_pkg::*;

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int FW = $clog2(WAYS + 1);
    localparam int QW = CMD_W + KEY_BITS + VALUE_BITS + BW;

    logic [CFG_W-1:0] r_bucket_count;
    logic [LIM_W-1:0] r_bucket_limit;
    logic [CFG_W-1:0] nb;
    logic [FW-1:0]    lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_COUNT_RST;
            r_bucket_limit <= BUCKET_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BUCKET_COUNT: r_bucket_count <= i_cfg_data;
                CFG_BUCKET_LIMIT: r_bucket_limit <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_bucket_count == '0) begin
            nb = CFG_W'(1);
        end else if (32'(r_bucket_count) > 32'(MAX_BUCKETS)) begin
            nb = CFG_W'(MAX_BUCKETS);
        end else begin
            nb = r_bucket_count;
        end
        if (r_bucket_limit == '0) begin
            lim = FW'(1);
        end else if (32'(r_bucket_limit) > 32'(WAYS)) begin
            lim = FW'(WAYS);
        end else begin
            lim = FW'(r_bucket_limit);
        end
    end

    logic                  accept, front_busy, clearing;
    logic                  q_push, q_pop, q_full, q_empty;
    logic [CMD_W-1:0]      f_cmd;
    logic [KEY_BITS-1:0]   f_key;
    logic [VALUE_BITS-1:0] f_val;
    logic [BW-1:0]         f_bkt;
    logic [QW-1:0]         q_out;

    assign busy   = front_busy || clearing;
    assign accept = start && !busy;

    blhc_front #(
        .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS), .BW(BW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_command(i_command), .i_key(i_key), .i_value(i_value),
        .i_nb(nb), .i_q_full(q_full), .o_q_push(q_push),
        .o_cmd(f_cmd), .o_key(f_key), .o_val(f_val), .o_bkt(f_bkt),
        .o_busy(front_busy)
    );

    blhc_queue #(.W(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(q_push), .i_data({f_cmd, f_key, f_val, f_bkt}),
        .i_pop(q_pop), .o_data(q_out), .o_full(q_full), .o_empty(q_empty)
    );

    blhc_back #(
        .MAX_BUCKETS(MAX_BUCKETS), .WAYS(WAYS), .KEY_BITS(KEY_BITS),
        .VALUE_BITS(VALUE_BITS), .BW(BW), .FW(FW)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_empty(q_empty), .o_q_pop(q_pop),
        .i_cmd(q_out[QW-1 -: CMD_W]),
        .i_key(q_out[QW-CMD_W-1 -: KEY_BITS]),
        .i_val(q_out[BW+VALUE_BITS-1 -: VALUE_BITS]),
        .i_bkt(q_out[BW-1:0]),
        .i_nb(nb), .i_lim(lim), .o_clearing(clearing),
        .o_valid(o_valid), .o_found(o_found), .o_read_value(o_read_value),
        .o_probes(o_probes), .o_evicted(o_evicted),
        .o_evicted_key(o_evicted_key)
    );
endmodule
